// ----- src/keyframe_linear_interpolator_assert.svh -----
// assertion macros shared by the keyframe interpolator checkers
// no dependencies; included by files that carry concurrent assertions
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_ASSERT_SVH

// consequence in the cycle after the antecedent, off during reset
`define KLI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kli assertion failed");

// same-cycle consequence, also checked around reset
`define KLI_ASSERT_NORST(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("kli assertion failed");

`endif

// ----- src/kli_pkg.sv -----
// shared types, constants and helpers of the keyframe linear interpolator
// no dependencies; imported by the top level, its checker and the testbench
`timescale 1ns / 1ps
`default_nettype none

package kli_pkg;

   // default keyframe table depth
   localparam int DEF_MAX_KEYS = 16;

   // request codes carried by req_type
   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_START = 2'd1,
      REQ_TICK  = 2'd2
   } req_code_type;

   // signed 32-bit add with saturation
   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] sum;
      sum = {a[31], a} + {b[31], b};
      if (sum[32] != sum[31]) begin
         sat_add = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         sat_add = sum[31:0];
      end
   endfunction

endpackage

`default_nettype wire

// ----- src/keyframe_linear_interpolator.sv -----
// keyframe linear interpolator top level: keyframe table, sequencer, shared divider
// depends on kli_pkg
`timescale 1ns / 1ps
`default_nettype none
//
// Usage
//   req channel (valid/stall): one item per request. req_type selects a keyframe
//   load into slot req_slot, a start of a run with req_key_count keys, or a
//   frame tick. csr_wr_en/csr_wr_data set the animation length in frames.
//   rsp channel (valid/stall): one item per tick while a run is active, with
//   the value of the frame, its index and a flag on the final frame.
// Sequencing
//   A load completes in the idle state. A tick that stays on its segment
//   passes through compare and finish. A start, or a tick that enters a new
//   segment, computes a slope with a restoring divider that resolves one
//   quotient bit per cycle. req_stall is high while the sequencer works on
//   an item.
// Reset and stall
//   Synchronous reset clears the run state, the length and the output; the
//   keyframe table keeps its contents and must be loaded before use.
//   A result waiting under rsp_stall does not block the next request; a
//   finished tick holds in its last step until the output register frees.
//
module keyframe_linear_interpolator #(
   parameter int MAX_KEYS = kli_pkg::DEF_MAX_KEYS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_type,
   input  wire logic [3:0]         req_slot,
   input  wire logic [15:0]        req_key_frame,
   input  wire logic signed [31:0] req_key_value,
   input  wire logic [4:0]         req_key_count,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_value,
   output logic [15:0]             rsp_frame_index,
   output logic                    rsp_last_frame,
   // configuration
   input  wire logic               csr_wr_en,
   input  wire logic [15:0]        csr_wr_data
);
   import kli_pkg::*;

   localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int KW = $clog2(MAX_KEYS + 1);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_TK_CMP  = 8'b0000_0010,
      ST_SL_A    = 8'b0000_0100,
      ST_SL_B    = 8'b0000_1000,
      ST_DIV     = 8'b0001_0000,
      ST_SL_DONE = 8'b0010_0000,
      ST_ADD     = 8'b0100_0000,
      ST_FINISH  = 8'b1000_0000
   } state_type;

   // registers and next values
   state_type          state_ff, state_in;
   logic [KW-1:0]      keys_ff, keys_in;
   logic [AW-1:0]      seg_ff, seg_in;
   logic signed [31:0] run_ff, run_in;
   logic signed [31:0] slope_ff, slope_in;
   logic [15:0]        cnt_ff, cnt_in;
   logic               active_ff, active_in;
   logic [15:0]        len_ff, len_in;
   logic               is_tick_ff, is_tick_in;
   logic [15:0]        a_frame_ff, a_frame_in;
   logic signed [31:0] a_value_ff, a_value_in;
   logic               neg_ff, neg_in;
   logic [32:0]        dvd_ff, dvd_in;
   logic [15:0]        rem_ff, rem_in;
   logic [15:0]        dvs_ff, dvs_in;
   logic [5:0]         step_ff, step_in;
   logic signed [31:0] pend_value_ff, pend_value_in;
   logic [15:0]        pend_frame_ff, pend_frame_in;
   logic               pend_last_ff, pend_last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [15:0]        rsp_frame_ff, rsp_frame_in;
   logic               rsp_last_ff, rsp_last_in;

   // keyframe memory, entry = {frame, value}
   logic [47:0]        key_mem_ff [MAX_KEYS];
   logic [47:0]        rd_data_ff;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [15:0]        rd_frame;
   logic signed [31:0] rd_value;

   // helpers
   logic               req_accept;
   logic               rsp_free;
   logic [AW-1:0]      seg_inc;
   logic               seg_room;
   logic [KW-1:0]      keys_sat;
   logic signed [32:0] dv;
   logic signed [16:0] df;
   logic [32:0]        dv_mag;
   logic [16:0]        df_mag;
   logic [16:0]        rem_sh;
   logic [17:0]        rem_diff;
   logic               rem_ge;
   logic               q_big;
   logic signed [31:0] run_step;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_frame_index = rsp_frame_ff;
   assign rsp_last_frame  = rsp_last_ff;

   assign rd_frame = rd_data_ff[47:32];
   assign rd_value = rd_data_ff[31:0];

   // table write on a load whose slot exists
   assign wr_addr = AW'(req_slot);
   assign wr_en   = req_accept && (req_type == REQ_LOAD) && (32'(req_slot) < MAX_KEYS);

   // segment bookkeeping
   assign seg_inc  = seg_ff + AW'(1);
   assign seg_room = ((KW+1)'(seg_ff) + (KW+1)'(1)) < (KW+1)'(keys_ff);
   assign run_step = sat_add(run_ff, slope_ff);

   // key count clamped between two and the table depth
   always_comb begin
      if (req_key_count < 5'd2) begin
         keys_sat = KW'(2);
      end else if (32'(req_key_count) > MAX_KEYS) begin
         keys_sat = KW'(MAX_KEYS);
      end else begin
         keys_sat = KW'(req_key_count);
      end
   end

   // slope operands from the two table entries
   assign dv     = {rd_value[31], rd_value} - {a_value_ff[31], a_value_ff};
   assign df     = $signed({1'b0, rd_frame}) - $signed({1'b0, a_frame_ff});
   assign dv_mag = dv[32] ? 33'(-dv) : 33'(dv);
   assign df_mag = df[16] ? 17'(-df) : 17'(df);

   // one restoring divide step
   assign rem_sh   = {rem_ff, dvd_ff[32]};
   assign rem_diff = {1'b0, rem_sh} - {2'b00, dvs_ff};
   assign rem_ge   = !rem_diff[17];
   assign q_big    = dvd_ff[32] | dvd_ff[31];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      keys_in       = keys_ff;
      seg_in        = seg_ff;
      run_in        = run_ff;
      slope_in      = slope_ff;
      cnt_in        = cnt_ff;
      active_in     = active_ff;
      len_in        = len_ff;
      is_tick_in    = is_tick_ff;
      a_frame_in    = a_frame_ff;
      a_value_in    = a_value_ff;
      neg_in        = neg_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      step_in       = step_ff;
      pend_value_in = pend_value_ff;
      pend_frame_in = pend_frame_ff;
      pend_last_in  = pend_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;
      rd_addr       = seg_ff;

      if (csr_wr_en) begin
         len_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_type)
                  REQ_START: begin
                     keys_in    = keys_sat;
                     cnt_in     = 16'd0;
                     seg_in     = '0;
                     active_in  = (len_ff != 16'd0);
                     is_tick_in = 1'b0;
                     rd_en      = 1'b1;
                     rd_addr    = '0;
                     state_in   = ST_SL_A;
                  end
                  REQ_TICK: begin
                     if (active_ff) begin
                        pend_value_in = run_ff;
                        pend_frame_in = cnt_ff;
                        pend_last_in  = ({1'b0, cnt_ff} + 17'd1) >= {1'b0, len_ff};
                        is_tick_in    = 1'b1;
                        rd_en         = 1'b1;
                        rd_addr       = seg_ff;
                        state_in      = ST_TK_CMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // frame of the current key is in rd_data
         ST_TK_CMP: begin
            if (seg_room) begin
               if (cnt_ff == rd_frame) begin
                  run_in     = rd_value;
                  a_frame_in = rd_frame;
                  a_value_in = rd_value;
                  rd_en      = 1'b1;
                  rd_addr    = seg_inc;
                  seg_in     = seg_inc;
                  state_in   = ST_SL_B;
               end else begin
                  run_in   = run_step;
                  state_in = ST_FINISH;
               end
            end else begin
               if (cnt_ff < rd_frame) begin
                  run_in = run_step;
               end
               state_in = ST_FINISH;
            end
         end
         // start: key 0 in rd_data, fetch key 1
         ST_SL_A: begin
            run_in     = rd_value;
            a_frame_in = rd_frame;
            a_value_in = rd_value;
            rd_en      = 1'b1;
            rd_addr    = seg_inc;
            seg_in     = seg_inc;
            state_in   = ST_SL_B;
         end
         // both keys known, set up the divide
         ST_SL_B: begin
            neg_in  = dv[32] ^ df[16];
            dvd_in  = dv_mag;
            rem_in  = 16'd0;
            dvs_in  = df_mag[15:0];
            step_in = 6'd32;
            if (df == 17'sd0) begin
               slope_in = 32'sd0;
               state_in = is_tick_ff ? ST_ADD : ST_IDLE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = rem_ge ? rem_diff[15:0] : rem_sh[15:0];
            dvd_in  = {dvd_ff[31:0], rem_ge};
            step_in = step_ff - 6'd1;
            if (step_ff == 6'd0) begin
               state_in = ST_SL_DONE;
            end
         end
         // sign and saturate the quotient
         ST_SL_DONE: begin
            if (neg_ff) begin
               slope_in = q_big ? 32'sh8000_0000 : -$signed(dvd_ff[31:0]);
            end else begin
               slope_in = q_big ? 32'sh7fff_ffff : $signed(dvd_ff[31:0]);
            end
            state_in = is_tick_ff ? ST_ADD : ST_IDLE;
         end
         ST_ADD: begin
            run_in   = run_step;
            state_in = ST_FINISH;
         end
         // hand the item to the output register
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = pend_value_ff;
               rsp_frame_in = pend_frame_ff;
               rsp_last_in  = pend_last_ff;
               cnt_in       = cnt_ff + 16'd1;
               if (pend_last_ff) begin
                  active_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         keys_ff      <= KW'(2);
         seg_ff       <= '0;
         run_ff       <= 32'sd0;
         slope_ff     <= 32'sd0;
         cnt_ff       <= 16'd0;
         active_ff    <= 1'b0;
         len_ff       <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         keys_ff      <= keys_in;
         seg_ff       <= seg_in;
         run_ff       <= run_in;
         slope_ff     <= slope_in;
         cnt_ff       <= cnt_in;
         active_ff    <= active_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and payload
   always_ff @(posedge clock) begin
      is_tick_ff    <= is_tick_in;
      a_frame_ff    <= a_frame_in;
      a_value_ff    <= a_value_in;
      neg_ff        <= neg_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      dvs_ff        <= dvs_in;
      step_ff       <= step_in;
      pend_value_ff <= pend_value_in;
      pend_frame_ff <= pend_frame_in;
      pend_last_ff  <= pend_last_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // keyframe memory write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[wr_addr] <= {req_key_frame, req_key_value};
      end
   end

   // keyframe memory read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= key_mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- src/kli_checker.sv -----
// port-level checker for the keyframe linear interpolator, bound to the top level
// depends on kli_pkg and keyframe_linear_interpolator_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "keyframe_linear_interpolator_assert.svh"

module kli_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic [1:0]         req_type,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [31:0] rsp_value,
   input wire logic [15:0]        rsp_frame_index,
   input wire logic               rsp_last_frame
);
   import kli_pkg::*;

   // a stalled result item holds
   `KLI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_value) && $stable(rsp_frame_index) && $stable(rsp_last_frame))

   // no result item right after reset
   `KLI_ASSERT_NORST(a_reset_clears, clock, $past(reset), !rsp_valid)

   // a start always runs the slope sequence
   `KLI_ASSERT_NEXT(a_start_busy, clock, reset, req_valid && !req_stall && req_type == REQ_START, req_stall)

   // loads, starts and unused codes never make a result item while the output is empty
   `KLI_ASSERT_NEXT(a_no_spurious_rsp, clock, reset, req_valid && !req_stall && req_type != REQ_TICK && !rsp_valid, !rsp_valid)

endmodule

bind keyframe_linear_interpolator kli_checker u_kli_checker (.*);

`default_nettype wire

// ----- tb/tb_keyframe_linear_interpolator.sv -----
// self-checking testbench for the keyframe linear interpolator: directed runs, random
// animation runs and output backpressure, checked against an in-bench value predictor
// depends on kli_pkg and keyframe_linear_interpolator
`timescale 1ns / 1ps

module tb_keyframe_linear_interpolator;
   import kli_pkg::*;

   localparam int KEY_SLOTS     = DEF_MAX_KEYS;
   localparam int RANDOM_ITEMS  = 700;
   localparam int SETTLE_CYCLES = 60;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 2000;
   localparam int REPORT_LINES  = 20;
   // request code the block must ignore
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;

   typedef struct {
      logic signed [31:0] value;
      logic [15:0]        frame_index;
      logic               last_frame;
   } frame_result_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_type = REQ_TICK;
   logic [3:0] req_slot = '0;
   logic [15:0] req_key_frame = '0;
   logic signed [31:0] req_key_value = '0;
   logic [4:0] req_key_count = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_value;
   logic [15:0] rsp_frame_index;
   logic rsp_last_frame;
   logic csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   // predictor state
   logic [15:0]        key_frames [KEY_SLOTS];
   logic signed [31:0] key_values [KEY_SLOTS];
   int                 keys_used;
   int                 cur_seg;
   logic signed [31:0] acc_value;
   logic signed [31:0] cur_slope;
   logic [15:0]        frame_no;
   bit                 running;
   logic [15:0]        length_reg;

   frame_result_type pending_frames [$];

   int mismatches = 0;
   int useful_items = 0;
   int loads_sent = 0;
   int starts_sent = 0;
   int frames_checked = 0;
   int seg_entries = 0;
   int sat_hits = 0;
   int tx_calm = 0;
   int rx_calm = 0;
   int stall_left = 0;
   int hold_left = 0;
   int hold_asks = 0;
   int hold_done = 0;

   keyframe_linear_interpolator DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_slot        (req_slot),
      .req_key_frame   (req_key_frame),
      .req_key_value   (req_key_value),
      .req_key_count   (req_key_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_frame_index (rsp_frame_index),
      .rsp_last_frame  (rsp_last_frame),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // idle length: mostly none, some short, a few long, with calm stretches
   function automatic int draw_gap(ref int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 199);
      if (r < 2) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 120) return 0;
      if (r < 180) return $urandom_range(1, 3);
      if (r < 195) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > longint'(VALUE_MAX)) begin
         sat_hits++;
         return VALUE_MAX;
      end
      if (v < longint'(VALUE_MIN)) begin
         sat_hits++;
         return VALUE_MIN;
      end
      return v[31:0];
   endfunction

   // slope between key j and key j+1, truncated toward zero
   function automatic logic signed [31:0] segment_slope(int j);
      longint dv;
      longint df;
      dv = longint'(key_values[j + 1]) - longint'(key_values[j]);
      df = longint'(key_frames[j + 1]) - longint'(key_frames[j]);
      if (df == 0) return '0;
      return clamp32(dv / df);
   endfunction

   // advance the predictor by one accepted item
   task automatic apply_item(logic [1:0] kind, logic [3:0] slot, logic [15:0] kf,
                             logic signed [31:0] kv, logic [4:0] kc);
      int k;
      bit is_last;
      frame_result_type want;
      case (kind)
         REQ_LOAD: begin
            key_frames[slot] = kf;
            key_values[slot] = kv;
            useful_items++;
            loads_sent++;
         end
         REQ_START: begin
            k = kc;
            if (k < 2) k = 2;
            if (k > KEY_SLOTS) k = KEY_SLOTS;
            keys_used = k;
            frame_no = '0;
            acc_value = key_values[0];
            cur_slope = segment_slope(0);
            cur_seg = 1;
            running = (length_reg != 0);
            useful_items++;
            starts_sent++;
         end
         REQ_TICK: begin
            if (running) begin
               is_last = (int'(frame_no) + 1 >= int'(length_reg));
               want.value = acc_value;
               want.frame_index = frame_no;
               want.last_frame = is_last;
               pending_frames.insert(pending_frames.size(), want);
               if (cur_seg + 1 < keys_used) begin
                  // entering the next segment reloads the key value
                  if (frame_no == key_frames[cur_seg]) begin
                     acc_value = key_values[cur_seg];
                     cur_slope = segment_slope(cur_seg);
                     cur_seg++;
                     seg_entries++;
                  end
                  acc_value = clamp32(longint'(acc_value) + longint'(cur_slope));
               end else if (frame_no < key_frames[cur_seg]) begin
                  // final segment ramps only up to its keyframe
                  acc_value = clamp32(longint'(acc_value) + longint'(cur_slope));
               end
               frame_no = frame_no + 16'd1;
               if (is_last) running = 1'b0;
               useful_items++;
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= REPORT_LINES) $display("mismatch @%0t: %s", $time, msg);
   endtask

   // offer one item, hold it until accepted, then predict
   task automatic send_item(logic [1:0] kind, logic [3:0] slot, logic [15:0] kf,
                            logic signed [31:0] kv, logic [4:0] kc);
      int gap;
      gap = draw_gap(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_slot <= slot;
      req_key_frame <= kf;
      req_key_value <= kv;
      req_key_count <= kc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_item(kind, slot, kf, kv, kc);
   endtask

   task automatic load_key(logic [3:0] slot, logic [15:0] kf, logic signed [31:0] kv);
      send_item(REQ_LOAD, slot, kf, kv, 5'($urandom));
   endtask

   task automatic start_run(logic [4:0] kc);
      send_item(REQ_START, 4'($urandom), 16'($urandom), $urandom, kc);
   endtask

   task automatic tick();
      send_item(REQ_TICK, 4'($urandom), 16'($urandom), $urandom, 5'($urandom));
   endtask

   // wait for all frames, then for any slope division still running
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_frames.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_length(logic [15:0] len);
      settle_block();
      csr_wr_en <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      length_reg = len;
   endtask

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 7))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return $urandom;
         default: return $signed($urandom_range(0, 26214400)) - 32'sd13107200;
      endcase
   endfunction

   function automatic logic [15:0] random_length();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hffff;
         2: return 16'($urandom_range(1, 65535));
         3: return 16'd1;
         default: return 16'($urandom_range(2, 40));
      endcase
   endfunction

   // ticks and an unused code with no run active
   task automatic test_idle_requests();
      tick();
      send_item(REQ_UNUSED, 4'($urandom), 16'($urandom), $urandom, 5'($urandom));
   endtask

   // extreme keys; a start with zero length leaves the block idle
   task automatic test_zero_length();
      load_key(4'd0, 16'd0, VALUE_MIN);
      load_key(4'd1, 16'd1, VALUE_MAX);
      load_key(4'd2, 16'd1, 32'sd0);
      load_key(4'd3, 16'd0, 32'sd0);
      load_key(4'd15, 16'hffff, -32'sd1);
      set_length(16'd0);
      start_run(5'd3);
      tick();
   endtask

   // saturated division, equal keyframe frames, key count clamped up from one
   task automatic test_saturated_slope();
      set_length(16'hffff);
      start_run(5'd3);
      repeat (3) tick();
      start_run(5'd1);
      repeat (2) tick();
   endtask

   // decreasing frame order gives a negative divisor and the sum saturates
   task automatic test_reverse_segment();
      load_key(4'd1, 16'd5, 32'sh0064_0000);
      load_key(4'd2, 16'd2, VALUE_MIN);
      start_run(5'd4);
      repeat (9) tick();
   endtask

   // shorter length mid-run: next tick is the last, the one after is ignored
   task automatic test_length_lowered();
      set_length(16'd3);
      repeat (2) tick();
   endtask

   // well-formed runs with random keys, some noise and restarts mixed in
   task automatic test_random_runs();
      int base;
      int k;
      int f;
      int n;
      logic [4:0] kc;
      for (int s = 0; s < KEY_SLOTS; s++) load_key(4'(s), 16'(s * 4), random_value());
      base = useful_items;
      while (useful_items - base < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) set_length(random_length());
         k = $urandom_range(2, KEY_SLOTS);
         f = $urandom_range(0, 3);
         for (int s = 0; s < k; s++) begin
            load_key(4'(s), ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'(f),
                     random_value());
            f += $urandom_range(0, 6);
         end
         kc = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'(k);
         start_run(kc);
         n = $urandom_range(2, 45);
         repeat (n) begin
            case ($urandom_range(0, 39))
               0: load_key(4'($urandom), 16'($urandom_range(0, 60)), random_value());
               1: send_item(REQ_UNUSED, 4'($urandom), 16'($urandom), $urandom,
                            5'($urandom));
               2: start_run(5'($urandom));
               default: tick();
            endcase
         end
      end
   endtask

   // receiver holds off while ticks keep coming, so the block backs up
   task automatic test_output_backpressure();
      set_length(16'hffff);
      start_run(5'd16);
      hold_asks <= hold_asks + 1;
      repeat (12) tick();
   endtask

   // result check and receiver stall generation
   always @(posedge clock) begin : response_side
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            report_mismatch($sformatf("unexpected frame %0d value %h",
                                      rsp_frame_index, rsp_value));
         end else begin
            want = pending_frames.pop_front();
            frames_checked++;
            if (rsp_value !== want.value)
               report_mismatch($sformatf("frame %0d value %h, want %h",
                                         want.frame_index, rsp_value, want.value));
            if (rsp_frame_index !== want.frame_index)
               report_mismatch($sformatf("frame index %0d, want %0d",
                                         rsp_frame_index, want.frame_index));
            if (rsp_last_frame !== want.last_frame)
               report_mismatch($sformatf("frame %0d last flag %b, want %b",
                                         want.frame_index, rsp_last_frame, want.last_frame));
         end
      end
      if (hold_asks != hold_done) begin
         hold_done = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         stall_left = draw_gap(rx_calm);
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // ends the run when nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("[keyframe_linear_interpolator] ERROR");
      $finish;
   end

   initial begin
      keys_used = 2;
      cur_seg = 0;
      acc_value = '0;
      cur_slope = '0;
      frame_no = '0;
      running = 1'b0;
      length_reg = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_requests();
      test_zero_length();
      test_saturated_slope();
      test_reverse_segment();
      test_length_lowered();
      test_random_runs();
      test_output_backpressure();

      settle_block();
      if (pending_frames.size() != 0)
         report_mismatch($sformatf("%0d frames never came out", pending_frames.size()));
      $display("covered %0d items: %0d key loads, %0d run starts, %0d frames checked",
               useful_items, loads_sent, starts_sent, frames_checked);
      $display("segment entries %0d, saturated results %0d, mismatches %0d",
               seg_entries, sat_hits, mismatches);
      if (mismatches == 0) begin
         $display("[keyframe_linear_interpolator] OK");
      end else begin
         $display("[keyframe_linear_interpolator] ERROR");
      end
      $finish;
   end

endmodule
